// ===== rtl/nirfd_pkg.sv =====
// Shared types, constants and reset values for the NEC infrared frame decoder.
// Used by every module of the decoder; depends on nothing else.

package nirfd_pkg;

    localparam int FRAME_BITS_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int INTERVAL_W  = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int BITS_RCVD_W = 5;
    localparam int FRAME_BYTES = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX   = 3'd5;

    localparam logic [CFG_W-1:0] RST_START_MIN = 16'd12000;
    localparam logic [CFG_W-1:0] RST_START_MAX = 16'd15000;
    localparam logic [CFG_W-1:0] RST_ZERO_MIN  = 16'd900;
    localparam logic [CFG_W-1:0] RST_ZERO_MAX  = 16'd1300;
    localparam logic [CFG_W-1:0] RST_ONE_MIN   = 16'd2000;
    localparam logic [CFG_W-1:0] RST_ONE_MAX   = 16'd2500;

    // Command codes that switch the lamps.
    localparam logic [7:0] CMD_RED_ON    = 8'h45;
    localparam logic [7:0] CMD_GREEN_ON  = 8'h46;
    localparam logic [7:0] CMD_BLUE_ON   = 8'h47;
    localparam logic [7:0] CMD_RED_OFF   = 8'h44;
    localparam logic [7:0] CMD_GREEN_OFF = 8'h40;
    localparam logic [7:0] CMD_BLUE_OFF  = 8'h43;

    localparam int LAMP_RED   = 0;
    localparam int LAMP_GREEN = 1;
    localparam int LAMP_BLUE  = 2;

    typedef enum logic [1:0] {
        CLS_START   = 2'd0,
        CLS_ZERO    = 2'd1,
        CLS_ONE     = 2'd2,
        CLS_INVALID = 2'd3
    } pulse_class_t;

    typedef struct packed {
        logic [CFG_W-1:0] start_min;
        logic [CFG_W-1:0] start_max;
        logic [CFG_W-1:0] zero_min;
        logic [CFG_W-1:0] zero_max;
        logic [CFG_W-1:0] one_min;
        logic [CFG_W-1:0] one_max;
    } window_cfg_t;

    typedef struct packed {
        pulse_class_t           pulse_class;
        logic [BITS_RCVD_W-1:0] bits_received;
        logic                   frame_done;
        logic                   frame_valid;
        logic [7:0]             address_byte;
        logic [7:0]             address_check;
        logic [7:0]             command_byte;
        logic [7:0]             command_check;
        logic [2:0]             lamps;
    } result_t;

endpackage

// ===== rtl/nirfd_classifier.sv =====
// Front end of the decoder: holds the window registers and classifies each interval.
// Depends on nirfd_pkg.

module nirfd_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [nirfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nirfd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [nirfd_pkg::INTERVAL_W-1:0] interval_us,
    output logic                           push_valid,
    input  logic                           push_ready,
    output nirfd_pkg::pulse_class_t        push_class
);
    import nirfd_pkg::*;

    window_cfg_t win_reg;
    window_cfg_t win_next;
    logic        hit_start;
    logic        hit_zero;
    logic        hit_one;

    always_comb
    begin
        win_next = win_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_MIN: win_next.start_min = cfg_data;
                REG_START_MAX: win_next.start_max = cfg_data;
                REG_ZERO_MIN:  win_next.zero_min  = cfg_data;
                REG_ZERO_MAX:  win_next.zero_max  = cfg_data;
                REG_ONE_MIN:   win_next.one_min   = cfg_data;
                REG_ONE_MAX:   win_next.one_max   = cfg_data;
                default:       win_next           = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.start_min <= RST_START_MIN;
            win_reg.start_max <= RST_START_MAX;
            win_reg.zero_min  <= RST_ZERO_MIN;
            win_reg.zero_max  <= RST_ZERO_MAX;
            win_reg.one_min   <= RST_ONE_MIN;
            win_reg.one_max   <= RST_ONE_MAX;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // Windows are open intervals; an empty window simply never matches.
    assign hit_start = (interval_us > win_reg.start_min) && (interval_us < win_reg.start_max);
    assign hit_zero  = (interval_us > win_reg.zero_min)  && (interval_us < win_reg.zero_max);
    assign hit_one   = (interval_us > win_reg.one_min)   && (interval_us < win_reg.one_max);

    always_comb
    begin
        priority if (hit_start)
            push_class = CLS_START;
        else if (hit_zero)
            push_class = CLS_ZERO;
        else if (hit_one)
            push_class = CLS_ONE;
        else
            push_class = CLS_INVALID;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

// ===== rtl/nirfd_queue.sv =====
// Short queue of classified intervals between the front end and the frame engine.
// Depends on nirfd_pkg.

module nirfd_queue #(
    parameter int QUEUE_DEPTH = nirfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  nirfd_pkg::pulse_class_t push_class,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output nirfd_pkg::pulse_class_t pop_class
);
    import nirfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pulse_class_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_class  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_class;
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on a lone push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on a lone pop");
`endif

endmodule

// ===== rtl/nirfd_frame_engine.sv =====
// Back end of the decoder: bit counter, shift byte, frame store, lamps and output register.
// Depends on nirfd_pkg.

module nirfd_frame_engine #(
    parameter int FRAME_BITS = nirfd_pkg::FRAME_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  nirfd_pkg::pulse_class_t pop_class,
    output logic                    out_valid,
    input  logic                    out_ready,
    output nirfd_pkg::result_t      result
);
    import nirfd_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       shift_reg;
    logic [7:0]       shift_next;
    logic [7:0]       frame_reg [FRAME_BYTES];
    logic [7:0]       frame_next [FRAME_BYTES];
    logic [2:0]       lamp_reg;
    logic [2:0]       lamp_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          result_reg;
    result_t          result_next;

    logic             pop;
    logic             is_bit;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       shift_new;
    logic [CNT_W-4:0] byte_num;
    logic [1:0]       byte_idx;
    logic             byte_full;
    logic             done;
    logic             valid;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    assign is_bit    = (pop_class == CLS_ZERO) || (pop_class == CLS_ONE);
    assign cnt_inc   = count_reg + 1'b1;
    assign shift_new = {pop_class == CLS_ONE, shift_reg[7:1]};
    assign byte_num  = cnt_inc[CNT_W-1:3];
    assign byte_idx  = 2'(byte_num - (CNT_W - 3)'(1));
    assign byte_full = is_bit && (cnt_inc[2:0] == 3'd0);
    assign done      = is_bit && (cnt_inc == CNT_W'(FRAME_BITS));

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_next[i] = frame_reg[i];
        if (byte_full)
            frame_next[byte_idx] = shift_new;
    end

    assign valid = done && (frame_next[0] == ~frame_next[1])
                        && (frame_next[2] == ~frame_next[3]);

    always_comb
    begin
        lamp_next = lamp_reg;
        if (valid)
        begin
            unique case (frame_next[2])
                CMD_RED_ON:    lamp_next[LAMP_RED]   = 1'b1;
                CMD_GREEN_ON:  lamp_next[LAMP_GREEN] = 1'b1;
                CMD_BLUE_ON:   lamp_next[LAMP_BLUE]  = 1'b1;
                CMD_RED_OFF:   lamp_next[LAMP_RED]   = 1'b0;
                CMD_GREEN_OFF: lamp_next[LAMP_GREEN] = 1'b0;
                CMD_BLUE_OFF:  lamp_next[LAMP_BLUE]  = 1'b0;
                default:       lamp_next             = lamp_reg;
            endcase
        end
    end

    // A start or invalid interval abandons the frame in progress.
    assign count_next = (!is_bit || done) ? '0 : cnt_inc;
    assign shift_next = is_bit ? shift_new : 8'h00;

    always_comb
    begin
        result_next.pulse_class   = pop_class;
        result_next.bits_received = BITS_RCVD_W'(count_next);
        result_next.frame_done    = done;
        result_next.frame_valid   = valid;
        result_next.address_byte  = frame_next[0];
        result_next.address_check = frame_next[1];
        result_next.command_byte  = frame_next[2];
        result_next.command_check = frame_next[3];
        result_next.lamps         = lamp_next;
    end

    assign out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            shift_reg     <= '0;
            lamp_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_reg[i] <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                count_reg <= count_next;
                shift_reg <= shift_next;
                lamp_reg  <= lamp_next;
                for (int i = 0; i < FRAME_BYTES; i++)
                    frame_reg[i] <= frame_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.frame_done) |-> (result_reg.bits_received == '0))
        else $error("completed frame left a nonzero bit count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.frame_valid) |-> result_reg.frame_done)
        else $error("frame flagged valid without completing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((result_reg.pulse_class == CLS_START)
                        || (result_reg.pulse_class == CLS_INVALID)))
        |-> ((result_reg.bits_received == '0) && !result_reg.frame_done))
        else $error("start or invalid interval did not clear the frame");
`endif

endmodule

// ===== rtl/nec_ir_frame_decoder_core.sv =====
// NEC infrared frame decoder, top level.
// Depends on nirfd_pkg, nirfd_classifier, nirfd_queue and nirfd_frame_engine.
//
// Usage:
//   Input channel (in_valid / in_ready / interval_us): one request per falling
//   edge of the receiver line, carrying the microseconds since the previous edge.
//   Output channel (out_valid / out_ready and the result fields): exactly one
//   result per request, in order: the interval class, the bit count, frame
//   completion and validity, the four frame bytes and the three lamp states.
//   Configuration: cfg_write with cfg_index and cfg_data sets one window bound
//   at a clock edge; only write while no request is in flight.
// Pipeline and throughput:
//   An accepted request is written into the queue, then popped into the frame
//   engine's output register, where its result is presented. One request per
//   cycle is sustained while out_ready stays high; the classifier compares are
//   combinational at the input and the engine updates its state once per request.
// Reset:
//   Windows return to their default bounds, counters, shift byte, frame store
//   and lamps clear, and the queue and output register empty.
// Stalls:
//   When out_ready is low the output register holds; the queue keeps taking
//   requests until it fills, then in_ready drops.

module nec_ir_frame_decoder_core #(
    parameter int FRAME_BITS  = nirfd_pkg::FRAME_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = nirfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [nirfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nirfd_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [nirfd_pkg::INTERVAL_W-1:0]  interval_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        pulse_class,
    output logic [nirfd_pkg::BITS_RCVD_W-1:0] bits_received,
    output logic                              frame_done,
    output logic                              frame_valid,
    output logic [7:0]                        address_byte,
    output logic [7:0]                        address_check,
    output logic [7:0]                        command_byte,
    output logic [7:0]                        command_check,
    output logic                              lamp_red,
    output logic                              lamp_green,
    output logic                              lamp_blue
);
    import nirfd_pkg::*;

    logic         push_valid;
    logic         push_ready;
    pulse_class_t push_class;
    logic         pop_valid;
    logic         pop_ready;
    pulse_class_t pop_class;
    result_t      result;

    nirfd_classifier u_classifier (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .interval_us(interval_us),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_class (push_class)
    );

    nirfd_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_class(push_class),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_class (pop_class)
    );

    nirfd_frame_engine #(
        .FRAME_BITS(FRAME_BITS)
    ) u_frame_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_class(pop_class),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result   (result)
    );

    assign pulse_class   = result.pulse_class;
    assign bits_received = result.bits_received;
    assign frame_done    = result.frame_done;
    assign frame_valid   = result.frame_valid;
    assign address_byte  = result.address_byte;
    assign address_check = result.address_check;
    assign command_byte  = result.command_byte;
    assign command_check = result.command_check;
    assign lamp_red      = result.lamps[LAMP_RED];
    assign lamp_green    = result.lamps[LAMP_GREEN];
    assign lamp_blue     = result.lamps[LAMP_BLUE];

endmodule
